// File: rtl/core/dsfl_pkg.sv
// dsfl_pkg: types and constants of the descriptor slot free-list allocator
// used by the allocator top level; depends on nothing else
`timescale 1ns / 1ps
`default_nettype none

package dsfl_pkg;

    // fixed field widths
    localparam int ADDR_W     = 48;
    localparam int STRIDE_W   = 11;
    localparam int SLOT_IDX_W = 10;
    localparam int CFG_IDX_W  = 1;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE    = 1'b1;

    // reset value of the stride register
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 11'd32;

    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef struct packed {
        t_mode               mode;
        logic [ADDR_W-1:0]   handle_address;
    } t_req;

    typedef struct packed {
        t_status                 status;
        logic [SLOT_IDX_W-1:0]   slot_index;
        logic [ADDR_W-1:0]       slot_address;
    } t_rsp;

endpackage

`default_nettype wire

// File: rtl/core/dsfl_ram.sv
// dsfl_ram: generic single-port-write, single-port-read RAM with registered read
// no package dependency; used for the free-list link memory
`timescale 1ns / 1ps
`default_nettype none

module dsfl_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic      [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/descriptor_slot_free_list_allocator.sv
// Descriptor slot allocator over SLOT_COUNT equally spaced slots. An allocate
// request pops the head of a linked free list held in a link RAM (one entry per
// slot, index plus valid bit) or, when the list is empty, takes the next
// never-used slot from a bump counter; a free request maps the address back to
// a slot index and pushes it. Requests are served one at a time. An allocate
// on a full heap goes straight to the result, and a pop first reads the link
// RAM. A free is rejected on range before the divider, or after it when the
// address is not an exact multiple of the stride or the slot was never handed
// out; the restoring divider yields one quotient bit per cycle. The next
// request is taken in the cycle after a result is registered, while that
// result may still be waiting downstream. The link RAM is not cleared after
// reset; an entry is only read after a free has written it.
// Depends on dsfl_pkg and dsfl_ram.
`timescale 1ns / 1ps
`default_nettype none

module descriptor_slot_free_list_allocator #(
    parameter int SLOT_COUNT = 1024
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // request channel
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire dsfl_pkg::t_req                      i_req,
    // result channel
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output dsfl_pkg::t_rsp                           o_rsp,
    // configuration writes
    input  wire logic                                i_cfg_we,
    input  wire logic [dsfl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [dsfl_pkg::ADDR_W-1:0]         i_cfg_data
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int RW = dsfl_pkg::STRIDE_W + IW;
    localparam int CW = (IW > 1) ? $clog2(IW) : 1;
    localparam int PW = dsfl_pkg::STRIDE_W + IW;
    localparam int AW = dsfl_pkg::ADDR_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_DIV,
        S_FIN,
        S_POP,
        S_MUL,
        S_OUT
    } t_state;

    t_state                          r_state;
    logic [AW-1:0]                   r_base;
    logic [dsfl_pkg::STRIDE_W-1:0]   r_stride;
    logic                            r_head_valid;
    logic [IW-1:0]                   r_head;
    logic [IW:0]                     r_fresh;
    logic [AW-1:0]                   r_addr;
    logic [IW-1:0]                   r_idx;
    dsfl_pkg::t_status               r_status;
    logic [RW-1:0]                   r_rem;
    logic [RW-1:0]                   r_div;
    logic [IW-1:0]                   r_q;
    logic [CW-1:0]                   r_cnt;
    logic [PW-1:0]                   r_prod;
    logic                            r_out_valid;
    dsfl_pkg::t_rsp                  r_out;

    logic                            n_accept;
    logic [AW:0]                     n_diff;
    logic [RW-1:0]                   n_lim;
    logic                            n_ge;
    logic [RW-1:0]                   n_rem;
    logic [IW:0]                     n_q;
    logic                            n_free_ok;
    logic                            n_out_load;
    logic                            n_mem_re;
    logic                            n_mem_we;
    logic [IW:0]                     n_mem_rdata;

    // handshake
    assign o_stall  = (r_state != S_IDLE);
    assign n_accept = i_valid && (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_rsp    = r_out;

    // range check: offset from base and the first offset past the last index
    assign n_diff = {1'b0, r_addr} - {1'b0, r_base};
    assign n_lim  = {r_stride, {IW{1'b0}}};

    // one restoring divider step
    assign n_ge  = (r_rem >= r_div);
    assign n_rem = n_ge ? (r_rem - r_div) : r_rem;
    assign n_q   = {r_q, n_ge};

    // exact division and the slot already handed out
    assign n_free_ok = (r_rem == '0) && ({1'b0, r_q} < r_fresh);

    // result register loads when empty or being drained
    assign n_out_load = (r_state == S_OUT) && (!r_out_valid || !i_stall);

    // link RAM control: read on pop, write on push
    assign n_mem_re = n_accept && (i_req.mode == dsfl_pkg::MODE_ALLOC) && r_head_valid;
    assign n_mem_we = (r_state == S_FIN) && n_free_ok;

    dsfl_ram #(
        .WIDTH (IW + 1),
        .DEPTH (SLOT_COUNT)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (n_mem_we),
        .i_waddr (r_q),
        .i_wdata ({r_head_valid, r_head}),
        .i_re    (n_mem_re),
        .i_raddr (r_head),
        .o_rdata (n_mem_rdata)
    );

    // sequencer, allocator state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_base       <= '0;
            r_stride     <= dsfl_pkg::STRIDE_RESET;
            r_head_valid <= 1'b0;
            r_head       <= '0;
            r_fresh      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    dsfl_pkg::CFG_HEAP_BASE: r_base   <= i_cfg_data;
                    dsfl_pkg::CFG_STRIDE:    r_stride <= i_cfg_data[dsfl_pkg::STRIDE_W-1:0];
                    default: ;
                endcase
            end

            // result loaded, or drained downstream
            if (n_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_addr <= i_req.handle_address;
                        if (i_req.mode == dsfl_pkg::MODE_FREE) begin
                            r_state <= S_CHK;
                        end else if (r_head_valid) begin
                            r_idx   <= r_head;
                            r_state <= S_POP;
                        end else if (r_fresh != (IW + 1)'(SLOT_COUNT)) begin
                            r_idx   <= r_fresh[IW-1:0];
                            r_fresh <= r_fresh + 1'b1;
                            r_state <= S_MUL;
                        end else begin
                            r_status <= dsfl_pkg::ST_FULL;
                            r_state  <= S_OUT;
                        end
                    end
                end
                S_CHK: begin
                    // below base, or quotient beyond the index range
                    if (n_diff[AW] || (n_diff[AW-1:0] >= AW'(n_lim))) begin
                        r_status <= dsfl_pkg::ST_BAD;
                        r_state  <= S_OUT;
                    end else begin
                        r_rem   <= n_diff[RW-1:0];
                        r_div   <= RW'(r_stride) << (IW - 1);
                        r_q     <= '0;
                        r_cnt   <= CW'(IW - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_div <= r_div >> 1;
                    r_q   <= n_q[IW-1:0];
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // push the freed slot onto the list, or reject the free
                    if (n_free_ok) begin
                        r_head       <= r_q;
                        r_head_valid <= 1'b1;
                        r_idx        <= r_q;
                        r_state      <= S_MUL;
                    end else begin
                        r_status <= dsfl_pkg::ST_BAD;
                        r_state  <= S_OUT;
                    end
                end
                S_POP: begin
                    // link of the popped slot becomes the new head
                    r_head       <= n_mem_rdata[IW-1:0];
                    r_head_valid <= n_mem_rdata[IW];
                    r_state      <= S_MUL;
                end
                S_MUL: begin
                    r_prod   <= PW'(r_idx) * PW'(r_stride);
                    r_status <= dsfl_pkg::ST_OK;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (n_out_load) begin
                        r_out.status  <= r_status;
                        if (r_status == dsfl_pkg::ST_OK) begin
                            r_out.slot_index   <= dsfl_pkg::SLOT_IDX_W'(r_idx);
                            r_out.slot_address <= r_base + AW'(r_prod);
                        end else begin
                            r_out.slot_index   <= '0;
                            r_out.slot_address <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: tb/testbench.sv
// testbench for descriptor_slot_free_list_allocator: directed and random
// allocate and free requests, each result checked against a typed row or an
// in-bench predictor; depends on dsfl_pkg and the allocator rtl
`timescale 1ns / 1ps

module testbench;

    import dsfl_pkg::*;

    localparam int SLOT_COUNT    = 1024;
    localparam int ROW_COUNT     = 23;
    localparam int TAIL_FIRST    = 17;
    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_LIMIT   = 4000;

    // clock, reset and block inputs, all known from time zero
    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_valid    = 1'b0;
    t_req                 i_req      = '0;
    logic                 i_stall    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = CFG_HEAP_BASE;
    logic [ADDR_W-1:0]    i_cfg_data = '0;
    logic                 o_stall;
    logic                 o_valid;
    t_rsp                 o_rsp;

    // predictor state: free list, bump counter and register copies
    bit                    pool_head_valid = 1'b0;
    logic [SLOT_IDX_W-1:0] pool_head       = '0;
    int                    bump_slot       = 0;
    logic [SLOT_IDX_W-1:0] slot_link [SLOT_COUNT];
    bit                    slot_link_valid [SLOT_COUNT];
    logic [ADDR_W-1:0]     heap_base       = '0;
    logic [STRIDE_W-1:0]   slot_stride     = STRIDE_RESET;

    // results awaited in order, and slots currently handed out
    t_rsp pending_results [$];
    int   issued_slots [$];
    t_rsp oldest_result;

    int mismatch_count   = 0;
    int send_idle_pct    = 0;
    int result_stall_pct = 0;

    // directed stimulus: typed rows carry their expected result
    typedef struct {
        t_mode             mode;
        logic [ADDR_W-1:0] addr;
        bit                typed;
        t_rsp              rsp;
    } t_directed_row;

    localparam t_rsp NOT_TYPED = '0;

    t_directed_row directed_rows [ROW_COUNT] = '{
        // reset registers: base 0, stride 32
        '{MODE_ALLOC, 48'h0,           1'b1, '{ST_OK,  10'd0, 48'h0}},
        '{MODE_ALLOC, 48'h0,           1'b1, '{ST_OK,  10'd1, 48'h20}},
        '{MODE_ALLOC, 48'h0,           1'b1, '{ST_OK,  10'd2, 48'h40}},
        '{MODE_FREE,  48'h20,          1'b1, '{ST_OK,  10'd1, 48'h20}},
        '{MODE_FREE,  48'h40,          1'b1, '{ST_OK,  10'd2, 48'h40}},
        '{MODE_ALLOC, 48'h0,           1'b1, '{ST_OK,  10'd2, 48'h40}},
        '{MODE_ALLOC, 48'h0,           1'b1, '{ST_OK,  10'd1, 48'h20}},
        '{MODE_ALLOC, 48'h0,           1'b1, '{ST_OK,  10'd3, 48'h60}},
        // misaligned, never issued, all ones, last slot not yet issued
        '{MODE_FREE,  48'h21,          1'b1, '{ST_BAD, 10'd0, 48'h0}},
        '{MODE_FREE,  48'h80,          1'b1, '{ST_BAD, 10'd0, 48'h0}},
        '{MODE_FREE,  48'hFFFF_FFFF_FFFF, 1'b1, '{ST_BAD, 10'd0, 48'h0}},
        '{MODE_FREE,  48'h7FE0,        1'b1, '{ST_BAD, 10'd0, 48'h0}},
        '{MODE_FREE,  48'h0,           1'b1, '{ST_OK,  10'd0, 48'h0}},
        '{MODE_FREE,  48'h60,          1'b1, '{ST_OK,  10'd3, 48'h60}},
        '{MODE_ALLOC, 48'h0,           1'b0, NOT_TYPED},
        '{MODE_ALLOC, 48'hFFFF_FFFF_FFFF, 1'b0, NOT_TYPED},
        '{MODE_ALLOC, 48'h0,           1'b0, NOT_TYPED},
        // tail, base 0x1000 stride 16: below base, then a double free
        '{MODE_FREE,  48'h0,           1'b1, '{ST_BAD, 10'd0, 48'h0}},
        '{MODE_FREE,  48'hFFF,         1'b1, '{ST_BAD, 10'd0, 48'h0}},
        '{MODE_FREE,  48'h1000,        1'b0, NOT_TYPED},
        '{MODE_FREE,  48'h1000,        1'b0, NOT_TYPED},
        '{MODE_ALLOC, 48'h0,           1'b0, NOT_TYPED},
        '{MODE_ALLOC, 48'h0,           1'b0, NOT_TYPED}
    };

    descriptor_slot_free_list_allocator #(
        .SLOT_COUNT (SLOT_COUNT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic logic [ADDR_W-1:0] random_address();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] slot_address_of(input int slot);
        return heap_base + ADDR_W'(slot) * ADDR_W'(slot_stride);
    endfunction

    // expected result of one request, updating the predicted free list
    function automatic t_rsp serve_request(input t_req req);
        t_rsp              res;
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] quotient;
        int                slot;
        res        = '0;
        res.status = ST_OK;
        slot       = 0;
        if (req.mode == MODE_ALLOC) begin
            if (pool_head_valid) begin
                slot            = pool_head;
                pool_head_valid = slot_link_valid[slot];
                pool_head       = slot_link[slot];
            end else if (bump_slot < SLOT_COUNT) begin
                slot = bump_slot;
                bump_slot++;
            end else begin
                res.status = ST_FULL;
            end
        end else if (slot_stride == '0 || req.handle_address < heap_base) begin
            res.status = ST_BAD;
        end else begin
            offset   = req.handle_address - heap_base;
            quotient = offset / ADDR_W'(slot_stride);
            if (offset % ADDR_W'(slot_stride) != '0 || quotient >= ADDR_W'(bump_slot)) begin
                res.status = ST_BAD;
            end else begin
                // push the slot onto the free list
                slot                  = int'(quotient);
                slot_link[slot]       = pool_head;
                slot_link_valid[slot] = pool_head_valid;
                pool_head             = SLOT_IDX_W'(slot);
                pool_head_valid       = 1'b1;
            end
        end
        if (res.status == ST_OK) begin
            res.slot_index   = SLOT_IDX_W'(slot);
            res.slot_address = slot_address_of(slot);
        end
        return res;
    endfunction

    // both registers, written back to back while the block is idle
    task automatic configure_heap(input logic [ADDR_W-1:0] base,
                                  input logic [STRIDE_W-1:0] stride);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_HEAP_BASE;
        i_cfg_data <= base;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_STRIDE;
        i_cfg_data <= ADDR_W'(stride);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        heap_base   = base;
        slot_stride = stride;
    endtask

    // present one request, hold it until taken, then record what it should give
    task automatic send_request(input t_req req, input bit typed, input t_rsp typed_rsp);
        t_rsp predicted;
        i_req   <= req;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predicted = serve_request(req);
        pending_results.push_back(typed ? typed_rsp : predicted);
        // track slots held by the caller, for well-formed frees
        if (predicted.status == ST_OK) begin
            if (req.mode == MODE_ALLOC) begin
                issued_slots.push_back(int'(predicted.slot_index));
            end else begin
                for (int k = 0; k < issued_slots.size(); k++) begin
                    if (issued_slots[k] == int'(predicted.slot_index)) begin
                        issued_slots.delete(k);
                        break;
                    end
                end
            end
        end
        // sender gap of random length
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic run_directed(input int first, input int last);
        t_req req;
        for (int n = first; n <= last; n++) begin
            req.mode           = directed_rows[n].mode;
            req.handle_address = directed_rows[n].addr;
            send_request(req, directed_rows[n].typed, directed_rows[n].rsp);
        end
        i_valid <= 1'b0;
    endtask

    // mostly allocates and frees of held slots, the rest malformed frees
    task automatic run_random_phase(input int count, input int alloc_pct);
        t_req req;
        int   pick;
        int   k;
        for (int n = 0; n < count; n++) begin
            pick               = $urandom_range(99);
            req.handle_address = random_address();
            if (pick < alloc_pct) begin
                req.mode = MODE_ALLOC;
            end else begin
                req.mode = MODE_FREE;
                if (pick < alloc_pct + (100 - alloc_pct) * 3 / 4 && issued_slots.size() != 0) begin
                    k                  = $urandom_range(issued_slots.size() - 1);
                    req.handle_address = slot_address_of(issued_slots[k]);
                end else begin
                    case ($urandom_range(3))
                        0: ;
                        1: if (slot_stride > 1) begin
                            req.handle_address = slot_address_of($urandom_range(SLOT_COUNT - 1))
                                + ADDR_W'($urandom_range(slot_stride - 1, 1));
                        end
                        2: req.handle_address = heap_base - ADDR_W'($urandom_range(256, 1));
                        default: req.handle_address = slot_address_of(bump_slot);
                    endcase
                end
            end
            send_request(req, 1'b0, NOT_TYPED);
        end
        i_valid <= 1'b0;
    endtask

    // wait for every awaited result, then let the block fall quiet
    task automatic settle_results();
        int waited;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
            pending_results.delete();
        end
    endtask

    // receiver stall
    always @(posedge i_clk) begin
        i_stall <= (result_stall_pct > 0 && $urandom_range(99) < result_stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing awaited: %p", o_rsp));
            end else begin
                oldest_result = pending_results.pop_front();
                if (o_rsp.status !== oldest_result.status)
                    report_mismatch($sformatf("status %0d, wanted %0d",
                        o_rsp.status, oldest_result.status));
                if (o_rsp.slot_index !== oldest_result.slot_index)
                    report_mismatch($sformatf("slot_index %0d, wanted %0d",
                        o_rsp.slot_index, oldest_result.slot_index));
                if (o_rsp.slot_address !== oldest_result.slot_address)
                    report_mismatch($sformatf("slot_address %h, wanted %h",
                        o_rsp.slot_address, oldest_result.slot_address));
            end
        end
    end

    // stimulus sequence
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset register values, no idling
        run_directed(0, TAIL_FIRST - 1);
        settle_results();

        // high base, widest nominal stride, sender gaps
        configure_heap(random_address() | 48'h8000_0000_0000, 11'd1024);
        send_idle_pct    = 48;
        result_stall_pct = 0;
        run_random_phase(100, 55);
        settle_results();

        // unit stride near the top of the address space, so addresses wrap
        configure_heap(48'hFFFF_FFFF_FF00, 11'd1);
        send_idle_pct    = 0;
        result_stall_pct = 48;
        run_random_phase(100, 55);
        settle_results();

        // zero stride: every free rejected, every allocate at the base
        configure_heap(48'hFFFF_FFFF_FFFF, 11'd0);
        send_idle_pct    = 28;
        result_stall_pct = 28;
        run_random_phase(40, 50);
        settle_results();

        // stride above the nominal range, allocate heavy
        configure_heap(48'h0000_0012_3440, 11'h7FF);
        run_random_phase(140, 90);
        settle_results();

        // below base and double free, no idling
        configure_heap(48'h1000, 11'd16);
        send_idle_pct    = 0;
        result_stall_pct = 0;
        run_directed(TAIL_FIRST, ROW_COUNT - 1);
        settle_results();

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // hang guard
    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: descriptor_slot_free_list_allocator.f
rtl/core/dsfl_pkg.sv
rtl/core/dsfl_ram.sv
rtl/core/descriptor_slot_free_list_allocator.sv
tb/testbench.sv
